// ===== rtl/ift_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ift_pkg
// Shared constants and types of the interpolating function table.
// ----------------------------------------------------------------------------
package ift_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int DIV_BITS    = 32;     // quotient bits per divide
    localparam int DATA_W      = 32;
    localparam int STEP_W      = 31;
    localparam int COUNT_W     = 9;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_START     = 2'd0,
        REG_STEP        = 2'd1,
        REG_ENTRY_COUNT = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg_idx;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

endpackage

// ===== rtl/ift_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ift_in_if
// Request channel: table loads and queries.
// ----------------------------------------------------------------------------
interface ift_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] query_x;

    modport source (output valid, kind, entry_index, entry_value, query_x, input ready);
    modport sink   (input valid, kind, entry_index, entry_value, query_x, output ready);
endinterface

// ===== rtl/ift_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ift_out_if
// Result channel: interpolated value and range flag.
// ----------------------------------------------------------------------------
interface ift_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] result_value;
    logic        in_range;

    modport source (output valid, result_value, in_range, input ready);
    modport sink   (input valid, result_value, in_range, output ready);
endinterface

// ===== rtl/ift_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ift_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface ift_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ift_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ift_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ift_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/ift_udiv_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ift_udiv_pipe
// Restoring unsigned divider, one quotient bit per stage.
// Dividend is {i_r0, i_lo}; i_r0 must be below the divisor.
// ----------------------------------------------------------------------------
module ift_udiv_pipe (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [ift_pkg::STEP_W-1:0]    i_r0,
    input  logic [ift_pkg::DIV_BITS-1:0]  i_lo,
    input  logic [ift_pkg::STEP_W-1:0]    i_div,
    output logic [ift_pkg::DIV_BITS-1:0]  o_quo,
    output logic [ift_pkg::STEP_W-1:0]    o_rem
);
    localparam int N = ift_pkg::DIV_BITS;
    localparam int W = ift_pkg::STEP_W;

    logic [W-1:0] r_r  [N];
    logic [N-1:0] r_lo [N];
    logic [N-1:0] r_q  [N];
    logic [W-1:0] n_r  [N];
    logic [N-1:0] n_lo [N];
    logic [N-1:0] n_q  [N];

    always_comb begin
        logic [W-1:0] r;
        logic [N-1:0] lo;
        logic [N-1:0] q;
        logic [W:0]   t;
        logic         ge;
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                r  = i_r0;
                lo = i_lo;
                q  = '0;
            end else begin
                r  = r_r[k-1];
                lo = r_lo[k-1];
                q  = r_q[k-1];
            end
            t  = {r, lo[N-1]};
            ge = (t >= {1'b0, i_div});
            n_r[k]  = ge ? W'(t - {1'b0, i_div}) : t[W-1:0];
            n_lo[k] = {lo[N-2:0], 1'b0};
            n_q[k]  = {q[N-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_r[k]  <= n_r[k];
                r_lo[k] <= n_lo[k];
                r_q[k]  <= n_q[k];
            end
        end
    end

    assign o_quo = r_q[N-1];
    assign o_rem = r_r[N-1];
endmodule

// ===== rtl/interpolating_function_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interpolating_function_table_unit
// Uniform-grid sample table with linear interpolation, signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : requests. kind 0 loads entry_value at entry_index, kind 1
//            queries query_x. Loads give no result, queries give one.
//   o_out  : result_value and in_range, in request order.
//   i_cfg  : register writes (x_start, step, entry_count), always ready;
//            write only while no query is in flight.
// Throughput: one request per cycle while the output does not stall. A query
//   passes one input stage, 32 stages of the index divider, the table read,
//   multiply, sum, magnitude, 32 stages of the interpolation divider and
//   the output register. The two dividers set the latency.
// Loads travel with the queries and write the table at the read stage,
// so every query sees exactly the loads issued before it.
// Reset clears the pipeline and sets x_start 0, step 65536, entry_count 256;
// the table keeps its contents and must be loaded before use.
// Stall: the output register holds its result; the pipeline keeps moving
// and accepting requests until a valid item reaches the last stage.
// ----------------------------------------------------------------------------
module interpolating_function_table_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ift_in_if.sink    i_in,
    ift_out_if.source o_out,
    ift_cfg_if.sink   i_cfg
);
    localparam int N  = ift_pkg::DIV_BITS;
    localparam int AW = ift_pkg::ADDR_W;

    // configuration
    logic signed [31:0]              r_x_start;
    logic [ift_pkg::STEP_W-1:0]      r_step;
    logic [ift_pkg::COUNT_W-1:0]     r_count;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_start <= '0;
            r_step    <= ift_pkg::STEP_W'(65536);
            r_count   <= ift_pkg::COUNT_W'(256);
        end else if (i_cfg.valid) begin
            unique case (ift_pkg::t_reg_idx'(i_cfg.index))
                ift_pkg::REG_X_START:     r_x_start <= i_cfg.data;
                ift_pkg::REG_STEP:        r_step    <= i_cfg.data[ift_pkg::STEP_W-1:0];
                ift_pkg::REG_ENTRY_COUNT: r_count   <= i_cfg.data[ift_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline enable: stop only when a result would overrun the output
    logic en;
    logic r_out_v;
    logic r_d2_v [N];
    assign en = !(r_out_v && !o_out.ready && r_d2_v[N-1]);
    assign i_in.ready = en;

    // stage 0
    logic        r_s0_v, r_s0_kind, r_s0_bad;
    logic [7:0]  r_s0_eidx;
    logic [31:0] r_s0_eval, r_s0_ud;
    logic [32:0] d;
    assign d = {i_in.query_x[31], i_in.query_x} - {r_x_start[31], r_x_start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_in.valid;
        end
        if (en) begin
            r_s0_kind <= i_in.kind;
            r_s0_eidx <= i_in.entry_index;
            r_s0_eval <= i_in.entry_value;
            r_s0_ud   <= d[31:0];
            r_s0_bad  <= d[32] || (r_step == '0);
        end
    end

    // index divider and its sideband
    logic [N-1:0]               d1_quo;
    logic [ift_pkg::STEP_W-1:0] d1_rem;

    ift_udiv_pipe u_div_idx (
        .i_clk (i_clk),
        .i_en  (en),
        .i_r0  ('0),
        .i_lo  (r_s0_ud),
        .i_div (r_step),
        .o_quo (d1_quo),
        .o_rem (d1_rem)
    );

    logic        r_d1_v    [N];
    logic        r_d1_kind [N];
    logic        r_d1_bad  [N];
    logic [7:0]  r_d1_eidx [N];
    logic [31:0] r_d1_eval [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_d1_v[k] <= 1'b0;
        end else if (en) begin
            r_d1_v[0] <= r_s0_v;
            for (int k = 1; k < N; k++) r_d1_v[k] <= r_d1_v[k-1];
        end
        if (en) begin
            r_d1_kind[0] <= r_s0_kind;
            r_d1_bad[0]  <= r_s0_bad;
            r_d1_eidx[0] <= r_s0_eidx;
            r_d1_eval[0] <= r_s0_eval;
            for (int k = 1; k < N; k++) begin
                r_d1_kind[k] <= r_d1_kind[k-1];
                r_d1_bad[k]  <= r_d1_bad[k-1];
                r_d1_eidx[k] <= r_d1_eidx[k-1];
                r_d1_eval[k] <= r_d1_eval[k-1];
            end
        end
    end

    // stage 1: range checks, table read and load write
    logic                        s1_load, s1_query, s1_hit, s1_ok;
    logic [ift_pkg::COUNT_W-1:0] cnt_eff;
    logic [AW-1:0]               a0, a1;

    assign cnt_eff  = (r_count > ift_pkg::COUNT_W'(ift_pkg::TABLE_DEPTH))
                    ? ift_pkg::COUNT_W'(ift_pkg::TABLE_DEPTH) : r_count;
    assign s1_load  = r_d1_v[N-1] && (r_d1_kind[N-1] == ift_pkg::KIND_LOAD)
                    && (32'(r_d1_eidx[N-1]) < 32'(ift_pkg::TABLE_DEPTH));
    assign s1_query = r_d1_v[N-1] && (r_d1_kind[N-1] == ift_pkg::KIND_QUERY);
    assign s1_hit   = (d1_rem == '0);
    assign s1_ok    = !r_d1_bad[N-1] && (s1_hit
                    ? ({1'b0, d1_quo} < 33'(cnt_eff))
                    : (({1'b0, d1_quo} + 33'd1) < 33'(cnt_eff)));
    assign a0 = d1_quo[AW-1:0];
    assign a1 = a0 + AW'(1);

    logic [31:0] y0_raw, y1_raw;

    ift_ram #(.WIDTH(32), .DEPTH(ift_pkg::TABLE_DEPTH)) u_ram_lo (
        .i_clk   (i_clk),
        .i_we    (en && s1_load),
        .i_waddr (r_d1_eidx[N-1][AW-1:0]),
        .i_wdata (r_d1_eval[N-1]),
        .i_re    (en),
        .i_raddr (a0),
        .o_rdata (y0_raw)
    );

    ift_ram #(.WIDTH(32), .DEPTH(ift_pkg::TABLE_DEPTH)) u_ram_hi (
        .i_clk   (i_clk),
        .i_we    (en && s1_load),
        .i_waddr (r_d1_eidx[N-1][AW-1:0]),
        .i_wdata (r_d1_eval[N-1]),
        .i_re    (en),
        .i_raddr (a1),
        .o_rdata (y1_raw)
    );

    // stage 2: table data out, products
    logic                        r_s2_v, r_s2_hit, r_s2_ok;
    logic [ift_pkg::STEP_W-1:0]  r_s2_rem;
    logic signed [31:0]          y0, y1, rem_s, crem_s;
    logic signed [63:0]          p0, p1;

    assign y0     = y0_raw;
    assign y1     = y1_raw;
    assign rem_s  = {1'b0, r_s2_rem};
    assign crem_s = {1'b0, ift_pkg::STEP_W'(r_step - r_s2_rem)};
    assign p1     = rem_s * y1;
    assign p0     = crem_s * y0;

    // stages 3..5: sum, magnitude
    logic               r_s3_v, r_s3_hit, r_s3_ok;
    logic signed [31:0] r_s3_y0;
    logic signed [63:0] r_s3_p0, r_s3_p1;
    logic               r_s4_v, r_s4_hit, r_s4_ok;
    logic signed [31:0] r_s4_y0;
    logic signed [63:0] r_s4_num;
    logic               r_s5_v, r_s5_hit, r_s5_ok, r_s5_neg;
    logic signed [31:0] r_s5_y0;
    logic [62:0]        r_s5_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= s1_query;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
        end
        if (en) begin
            r_s2_hit <= s1_hit;
            r_s2_ok  <= s1_ok;
            r_s2_rem <= d1_rem;
            r_s3_hit <= r_s2_hit;
            r_s3_ok  <= r_s2_ok;
            r_s3_y0  <= y0;
            r_s3_p0  <= p0;
            r_s3_p1  <= p1;
            r_s4_hit <= r_s3_hit;
            r_s4_ok  <= r_s3_ok;
            r_s4_y0  <= r_s3_y0;
            r_s4_num <= r_s3_p0 + r_s3_p1;
            r_s5_hit <= r_s4_hit;
            r_s5_ok  <= r_s4_ok;
            r_s5_y0  <= r_s4_y0;
            r_s5_neg <= r_s4_num[63];
            r_s5_mag <= r_s4_num[63] ? 63'(-r_s4_num) : r_s4_num[62:0];
        end
    end

    // interpolation divider: |num| / step, quotient fits 32 bits
    logic [N-1:0]               d2_quo;
    logic [ift_pkg::STEP_W-1:0] d2_rem;

    ift_udiv_pipe u_div_interp (
        .i_clk (i_clk),
        .i_en  (en),
        .i_r0  (r_s5_mag[62:32]),
        .i_lo  (r_s5_mag[31:0]),
        .i_div (r_step),
        .o_quo (d2_quo),
        .o_rem (d2_rem)
    );

    logic        r_d2_hit [N];
    logic        r_d2_ok  [N];
    logic        r_d2_neg [N];
    logic [31:0] r_d2_y0  [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_d2_v[k] <= 1'b0;
        end else if (en) begin
            r_d2_v[0] <= r_s5_v;
            for (int k = 1; k < N; k++) r_d2_v[k] <= r_d2_v[k-1];
        end
        if (en) begin
            r_d2_hit[0] <= r_s5_hit;
            r_d2_ok[0]  <= r_s5_ok;
            r_d2_neg[0] <= r_s5_neg;
            r_d2_y0[0]  <= r_s5_y0;
            for (int k = 1; k < N; k++) begin
                r_d2_hit[k] <= r_d2_hit[k-1];
                r_d2_ok[k]  <= r_d2_ok[k-1];
                r_d2_neg[k] <= r_d2_neg[k-1];
                r_d2_y0[k]  <= r_d2_y0[k-1];
            end
        end
    end

    // output register; remainder of the second divide is not needed
    logic [31:0] res;
    logic        unused_rem;
    assign unused_rem = ^d2_rem;

    always_comb begin
        if (!r_d2_ok[N-1]) begin
            res = '0;
        end else if (r_d2_hit[N-1]) begin
            res = r_d2_y0[N-1];
        end else if (r_d2_neg[N-1]) begin
            res = -d2_quo;
        end else begin
            res = d2_quo;
        end
    end

    logic [31:0] r_out_val;
    logic        r_out_rng;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (!r_out_v || o_out.ready) begin
            r_out_v <= r_d2_v[N-1];
        end
        if (!r_out_v || o_out.ready) begin
            r_out_val <= res;
            r_out_rng <= r_d2_ok[N-1] && !(unused_rem && 1'b0);
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.result_value = r_out_val;
    assign o_out.in_range     = r_out_rng;
endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for interpolating_function_table_unit. Loads the whole
// table, runs directed edge queries, then random loads and queries under
// several grid settings and idle patterns. Each query result is compared
// against a local Q16.16 interpolation predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int QUIET_LIMIT = 3000;   // cycles with no handshake at all
    localparam int DRAIN_WAIT  = 80;     // covers the full pipeline

    typedef struct {
        logic signed [31:0] value;
        logic               in_range;
    } t_table_answer;

    logic i_clk;
    logic i_rst_n;

    ift_in_if  in_if ();
    ift_out_if out_if ();
    ift_cfg_if cfg_if ();

    interpolating_function_table_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // predictor state
    logic signed [31:0] samples [ift_pkg::TABLE_DEPTH];
    longint             grid_x_start;
    longint             grid_step;
    int                 grid_count;
    t_table_answer      pending_answers [$];

    int mismatches;
    int quiet_cycles;
    int send_idle_pct;
    int recv_idle_pct;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_table_answer interp_answer(logic signed [31:0] x);
        longint        d, idx, rem, y0, y1, num, cnt;
        t_table_answer ans;
        ans.value    = '0;
        ans.in_range = 1'b0;
        cnt = (grid_count > ift_pkg::TABLE_DEPTH) ? ift_pkg::TABLE_DEPTH : grid_count;
        d   = longint'(x) - grid_x_start;
        if (grid_step != 0 && d >= 0) begin
            idx = d / grid_step;
            rem = d % grid_step;
            if (rem == 0) begin
                if (idx < cnt) begin
                    ans.value    = samples[idx];
                    ans.in_range = 1'b1;
                end
            end else if (idx + 1 < cnt) begin
                y0  = samples[idx];
                y1  = samples[idx + 1];
                num = rem * y1 + (grid_step - rem) * y0;
                ans.value    = 32'(num / grid_step);
                ans.in_range = 1'b1;
            end
        end
        return ans;
    endfunction

    // request / register monitor, result checker and watchdog
    always @(posedge i_clk) begin
        t_table_answer exp_ans;
        logic          any_hs;
        any_hs = 1'b0;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            any_hs = 1'b1;
            if (in_if.kind == ift_pkg::KIND_LOAD)
                samples[in_if.entry_index] = in_if.entry_value;
            else
                pending_answers.push_back(interp_answer(in_if.query_x));
        end
        if (i_rst_n && cfg_if.valid && cfg_if.ready) begin
            any_hs = 1'b1;
            case (ift_pkg::t_reg_idx'(cfg_if.index))
                ift_pkg::REG_X_START:     grid_x_start = longint'($signed(cfg_if.data));
                ift_pkg::REG_STEP:        grid_step    = longint'(cfg_if.data[30:0]);
                ift_pkg::REG_ENTRY_COUNT: grid_count   = int'(cfg_if.data[8:0]);
                default: ;
            endcase
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            any_hs = 1'b1;
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with no query pending: value %0d in_range %0b",
                             out_if.result_value, out_if.in_range);
            end else begin
                exp_ans = pending_answers.pop_front();
                if (out_if.result_value !== exp_ans.value ||
                    out_if.in_range !== exp_ans.in_range) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: expected value %0d in_range %0b, got %0d %0b",
                                 exp_ans.value, exp_ans.in_range,
                                 out_if.result_value, out_if.in_range);
                end
            end
        end
        quiet_cycles = any_hs ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic send_req(logic kind, logic [7:0] idx, logic signed [31:0] val,
                            logic signed [31:0] x);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid       = 1'b1;
        in_if.kind        = kind;
        in_if.entry_index = idx;
        in_if.entry_value = val;
        in_if.query_x     = x;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    task automatic load_entry(int idx, logic signed [31:0] val);
        send_req(ift_pkg::KIND_LOAD, 8'(idx), val, 32'($urandom));
    endtask

    task automatic query(logic signed [31:0] x);
        send_req(ift_pkg::KIND_QUERY, 8'($urandom), 32'($urandom), x);
    endtask

    // all queries answered and in-flight loads retired
    task automatic drain();
        in_if.valid = 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(ift_pkg::t_reg_idx idx, logic [31:0] data);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = data;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic set_grid(logic [31:0] xs, logic [31:0] st, logic [31:0] cnt);
        drain();
        write_reg(ift_pkg::REG_X_START, xs);
        write_reg(ift_pkg::REG_STEP, st);
        write_reg(ift_pkg::REG_ENTRY_COUNT, cnt);
    endtask

    function automatic logic signed [31:0] pick_query_x();
        longint base, cnt, idx, rem, x;
        int     mode;
        cnt  = (grid_count > ift_pkg::TABLE_DEPTH) ? ift_pkg::TABLE_DEPTH : grid_count;
        mode = $urandom_range(0, 9);
        if (grid_step == 0 || cnt == 0 || mode == 9)
            return 32'($urandom);
        rem = (mode == 6) ? 0 : $urandom_range(0, 32'(grid_step - 1));
        if (mode == 7)
            idx = cnt - 1 + $urandom_range(0, 2);
        else
            idx = $urandom_range(0, 32'(cnt - 1));
        base = grid_x_start;
        x    = (mode == 8) ? base - 1 - $urandom_range(0, 1000) : base + idx * grid_step + rem;
        if (x > 64'sd2147483647 || x < -64'sd2147483648)
            return 32'($urandom);
        return 32'(x);
    endfunction

    task automatic test_table_fill();
        for (int i = 0; i < ift_pkg::TABLE_DEPTH; i++)
            load_entry(i, 32'($urandom));
    endtask

    task automatic test_edges();
        load_entry(0, 32'sh7FFF_FFFF);
        load_entry(1, 32'sh8000_0000);
        load_entry(255, 32'sh8000_0000);
        load_entry(254, 32'sh7FFF_FFFF);
        query(32'sh0000_0000);                   // first grid point
        query(32'sh0000_8000);                   // midpoint, extreme samples
        query(32'sh0000_0001);
        query(32'sh00FF_0000);                   // last grid point
        query(32'sh00FE_FFFF);                   // inside last interval
        query(32'sh00FF_0001);                   // past last entry
        query(32'shFFFF_FFFF);                   // below origin
        query(32'sh7FFF_FFFF);
        query(32'sh8000_0000);
        load_entry(0, 32'sh0000_0000);
        query(32'sh0000_4000);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0)
                load_entry($urandom_range(0, ift_pkg::TABLE_DEPTH - 1), 32'($urandom));
            else
                query(pick_query_x());
        end
    endtask

    task automatic test_grid_settings();
        send_idle_pct = 30;
        recv_idle_pct = 47;
        test_random(120);
        set_grid(32'h8000_0000, 32'd1, 32'd256);
        test_random(60);
        drain();                                 // pause until every request answered
        set_grid(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd2);
        test_random(30);

        send_idle_pct = 47;
        recv_idle_pct = 30;
        set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'd3);
        test_random(60);
        set_grid(32'hFFF0_0000, 32'h8000_0000, 32'd511);  // step reads zero
        test_random(25);
        set_grid(32'h0000_0000, 32'h0001_0000, 32'd0);
        write_reg(ift_pkg::REG_UNUSED, 32'($urandom));
        test_random(25);
        set_grid(32'h0000_0000, 32'h0000_0100, 32'd300); // count capped at depth
        test_random(60);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int p = 0; p < 3; p++) begin
            set_grid(32'($urandom), $urandom_range(1, 1 << 20), $urandom_range(1, 256));
            test_random(60);
        end
    endtask

    initial begin
        mismatches    = 0;
        quiet_cycles  = 0;
        send_idle_pct = 30;
        recv_idle_pct = 47;
        grid_x_start  = 0;
        grid_step     = 65536;
        grid_count    = 256;
        i_rst_n       = 1'b0;
        in_if.valid       = 1'b0;
        in_if.kind        = ift_pkg::KIND_LOAD;
        in_if.entry_index = '0;
        in_if.entry_value = '0;
        in_if.query_x     = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = ift_pkg::REG_X_START;
        cfg_if.data   = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_table_fill();
        test_edges();
        test_grid_settings();

        drain();
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
